@@ rtl/lufx_pkg.sv @@
package lufx_pkg;

	// integer bits kept for the gradient ratio, and its clip value
	localparam int RATIO_BITS = 15;
	localparam int RATIO_LIMIT = 32767;

	// shared pipeline control: global advance and the valid bit of the entering word
	typedef struct packed {
		logic advance;
		logic valid;
	} pipe_ctl_t;

endpackage

@@ rtl/lufx_div.sv @@
module lufx_div #(
	parameter int NB = 57,
	parameter int DB = 33,
	parameter int QB = 39,
	parameter int PW = 1
) (
	input  logic                clk,
	input  logic                arst_n,
	input  lufx_pkg::pipe_ctl_t in_ctl,
	input  logic [NB-1:0]       dividend,
	input  logic [DB-1:0]       divisor,
	input  logic [PW-1:0]       in_payload,
	output logic                out_valid,
	output logic [QB-1:0]       quotient,
	output logic [PW-1:0]       out_payload
);
	import lufx_pkg::*;

	// one restoring step per stage; the upper dividend bits must stay below the divisor
	logic [DB-1:0] rem_s [QB];
	logic [QB-1:0] bits_s [QB];
	logic [DB-1:0] dvs_s [QB];
	logic [PW-1:0] pay_s [QB];
	logic          vld_s [QB];

	for (genvar k = 0; k < QB; k++) begin : g_step
		logic [DB-1:0] rem_i;
		logic [QB-1:0] bits_i;
		logic [DB-1:0] dvs_i;
		logic [PW-1:0] pay_i;
		logic          vld_i;
		logic [DB:0]   trial;
		logic          take;

		if (k == 0) begin : g_first
			assign rem_i = DB'(dividend >> QB);
			assign bits_i = dividend[QB-1:0];
			assign dvs_i = divisor;
			assign pay_i = in_payload;
			assign vld_i = in_ctl.valid;
		end else begin : g_next
			assign rem_i = rem_s[k-1];
			assign bits_i = bits_s[k-1];
			assign dvs_i = dvs_s[k-1];
			assign pay_i = pay_s[k-1];
			assign vld_i = vld_s[k-1];
		end

		// trial subtract of the shifted remainder
		assign trial = {rem_i, bits_i[QB-1]};
		assign take = trial >= {1'b0, dvs_i};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (in_ctl.advance) begin
				vld_s[k] <= vld_i;
			end
		end

		always_ff @(posedge clk) begin
			if (in_ctl.advance) begin
				rem_s[k] <= take ? DB'(trial - {1'b0, dvs_i}) : DB'(trial);
				bits_s[k] <= {bits_i[QB-2:0], take};
				dvs_s[k] <= dvs_i;
				pay_s[k] <= pay_i;
			end
		end
	end

	assign out_valid = vld_s[QB-1];
	assign quotient = bits_s[QB-1];
	assign out_payload = pay_s[QB-1];

endmodule

@@ rtl/lufx_mul.sv @@
module lufx_mul #(
	parameter int AW = 32,
	parameter int BW = 32,
	parameter int PW = 1
) (
	input  logic                clk,
	input  logic                arst_n,
	input  lufx_pkg::pipe_ctl_t in_ctl,
	input  logic [AW-1:0]       a,
	input  logic [BW-1:0]       b,
	input  logic [PW-1:0]       in_payload,
	output logic                out_valid,
	output logic [AW+BW-1:0]    product,
	output logic [PW-1:0]       out_payload
);
	import lufx_pkg::*;

	localparam int AL = (AW + 1) / 2;
	localparam int AH = AW - AL;
	localparam int BL = (BW + 1) / 2;
	localparam int BH = BW - BL;
	localparam int FW = AW + BW;

	logic [AL+BL-1:0] ll_s1;
	logic [AL+BH-1:0] lh_s1;
	logic [AH-1:0]    ah_s1;
	logic [BW-1:0]    b_s1;
	logic [PW-1:0]    pay_s1;
	logic             vld_s1;
	logic [FW-1:0]    lo_s2;
	logic [AH+BL-1:0] hl_s2;
	logic [AH+BH-1:0] hh_s2;
	logic [PW-1:0]    pay_s2;
	logic             vld_s2;
	logic [FW-1:0]    prod_s3;
	logic [PW-1:0]    pay_s3;
	logic             vld_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (in_ctl.advance) begin
			vld_s1 <= in_ctl.valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	// low half of a against both halves of b, then high half, then the final sum
	always_ff @(posedge clk) begin
		if (in_ctl.advance) begin
			ll_s1 <= (AL+BL)'(a[AL-1:0]) * (AL+BL)'(b[BL-1:0]);
			lh_s1 <= (AL+BH)'(a[AL-1:0]) * (AL+BH)'(b[BW-1:BL]);
			ah_s1 <= a[AW-1:AL];
			b_s1 <= b;
			pay_s1 <= in_payload;
			lo_s2 <= FW'(ll_s1) + (FW'(lh_s1) << BL);
			hl_s2 <= (AH+BL)'(ah_s1) * (AH+BL)'(b_s1[BL-1:0]);
			hh_s2 <= (AH+BH)'(ah_s1) * (AH+BH)'(b_s1[BW-1:BL]);
			pay_s2 <= pay_s1;
			prod_s3 <= lo_s2 + (FW'(hl_s2) << AL) + (FW'(hh_s2) << (AL + BL));
			pay_s3 <= pay_s2;
		end
	end

	assign out_valid = vld_s3;
	assign product = prod_s3;
	assign out_payload = pay_s3;

endmodule

@@ rtl/limited_upwind_advection_flux.sv @@
// channel   direction  fields (lowest bit first)
// s_axis    in         tdata: left_value, center_value, right_value, velocity, step_over_width
// m_axis    out        tdata: flux; tuser: toward_higher, saturated
//
// one word accepted per cycle while m_axis is not stalled; the pipeline holds the
// two bit-per-stage dividers (ratio, limiter) and four 3-stage multipliers
// reset clears every valid bit, the output valid among them; payload and output data registers are not reset
// a stall on m_axis freezes the whole pipeline and drops s_axis_tready in the same cycle
module limited_upwind_advection_flux #(
	parameter int VALUE_BITS = 32,
	parameter int FRACTION_BITS = 24
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	// left_value, center_value, right_value, velocity, step_over_width
	input  logic [((5*VALUE_BITS-1+7)/8)*8-1:0] s_axis_tdata,
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	// flux
	output logic [((VALUE_BITS+7)/8)*8-1:0] m_axis_tdata,
	// toward_higher, saturated
	output logic [1:0] m_axis_tuser
);
	import lufx_pkg::*;

	localparam int V = VALUE_BITS;
	localparam int F = FRACTION_BITS;
	localparam int OUT_DW = ((V + 7) / 8) * 8;
	localparam int MW = V + 1;
	localparam int RW = F + RATIO_BITS;
	localparam int NB1 = MW + F;
	localparam int SQW = 2 * RW - F;
	localparam int DB2 = SQW + 1;
	localparam int NB2 = RW + F + 1;
	localparam int QB2 = F + 1;
	localparam int IW = V + 2;
	localparam int XW = 2 * V + 1 - F;
	localparam int MFW = XW + V - 1 - F;
	localparam int TW = 3 * V;
	localparam int P1W = TW + MW + 4;
	localparam int P2W = TW + MW + 3 + RW;
	localparam int P3W = TW + MW + 3;
	localparam int P4W = TW + 2;
	localparam int P5W = V + 2;
	localparam logic [RW-1:0] ONE_Q = RW'(1) << F;
	localparam logic [RW-1:0] LIM_Q = RW'(RATIO_LIMIT) << F;
	localparam logic [MFW-1:0] HALF_M = MFW'(1) << (V - 1);

	logic adv;

	// output register frees the pipeline whenever it is empty or being taken
	logic m_valid_q;
	assign adv = !m_valid_q || m_axis_tready;
	assign s_axis_tready = adv;

	// input word fields
	logic [V-1:0] left_value;
	logic [V-1:0] center_value;
	logic [V-1:0] right_value;
	logic [V-1:0] velocity;
	logic [V-2:0] step_over_width;
	assign left_value = s_axis_tdata[V-1:0];
	assign center_value = s_axis_tdata[2*V-1:V];
	assign right_value = s_axis_tdata[3*V-1:2*V];
	assign velocity = s_axis_tdata[4*V-1:3*V];
	assign step_over_width = s_axis_tdata[5*V-2:4*V];

	// upwind selection and differences
	logic          higher_d;
	logic [V-1:0]  up_d;
	logic [V-1:0]  down_d;
	logic [MW-1:0] num_d;
	logic [MW-1:0] den_d;
	logic [MW-1:0] spr_d;
	logic [MW-1:0] nmag_d;
	logic [MW-1:0] dmag_d;
	logic [MW-1:0] smag_d;
	logic [V-1:0]  speed_d;
	logic          special_d;

	assign higher_d = !velocity[V-1] && (velocity != '0);
	assign up_d = higher_d ? left_value : right_value;
	assign down_d = higher_d ? right_value : left_value;
	assign num_d = {down_d[V-1], down_d} - {center_value[V-1], center_value};
	assign den_d = {center_value[V-1], center_value} - {up_d[V-1], up_d};
	assign spr_d = {down_d[V-1], down_d} - {up_d[V-1], up_d};
	assign nmag_d = num_d[V] ? MW'(~num_d + 1'b1) : num_d;
	assign dmag_d = den_d[V] ? MW'(~den_d + 1'b1) : den_d;
	assign smag_d = spr_d[V] ? MW'(~spr_d + 1'b1) : spr_d;
	assign speed_d = velocity[V-1] ? V'(~velocity + 1'b1) : velocity;
	assign special_d = (velocity == '0) || (center_value == up_d);

	logic          vld_s1;
	logic [V-1:0]  center_s1;
	logic [V-1:0]  speed_s1;
	logic [V-2:0]  dtdx_s1;
	logic          higher_s1;
	logic [MW-1:0] nmag_s1;
	logic [MW-1:0] dmag_s1;
	logic [MW-1:0] smag_s1;
	logic          sneg_s1;
	logic          rneg_s1;
	logic          special_s1;

	// ratio clip test: quotient would reach 2^RATIO_BITS
	logic clip_d;
	assign clip_d = !special_s1 &&
		((MW + RATIO_BITS)'(nmag_s1) >= {dmag_s1, {RATIO_BITS{1'b0}}});

	logic          vld_s2;
	logic [MW-1:0] ndiv_s2;
	logic [MW-1:0] dmag_s2;
	logic [TW-1:0] tail_s2;
	logic [MW-1:0] smag_s2;
	logic          sneg_s2;
	logic          rneg_s2;
	logic          special_s2;
	logic          clip_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= s_axis_tvalid;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			center_s1 <= center_value;
			speed_s1 <= speed_d;
			dtdx_s1 <= step_over_width;
			higher_s1 <= higher_d;
			nmag_s1 <= nmag_d;
			dmag_s1 <= dmag_d;
			smag_s1 <= smag_d;
			sneg_s1 <= spr_d[V];
			rneg_s1 <= num_d[V] ^ den_d[V];
			special_s1 <= special_d;
			ndiv_s2 <= (special_s1 || clip_d) ? '0 : nmag_s1;
			dmag_s2 <= dmag_s1;
			tail_s2 <= {center_s1, speed_s1, dtdx_s1, higher_s1};
			smag_s2 <= smag_s1;
			sneg_s2 <= sneg_s1;
			rneg_s2 <= rneg_s1;
			special_s2 <= special_s1;
			clip_s2 <= clip_d;
		end
	end

	// gradient ratio divider
	pipe_ctl_t      ctl_div1;
	logic           vld_d1;
	logic [RW-1:0]  q1;
	logic [P1W-1:0] pay_d1;
	logic [TW-1:0]  tail_d1;
	logic [MW-1:0]  smag_d1;
	logic           sneg_d1;
	logic           rneg_d1;
	logic           special_d1;
	logic           clip_d1;

	assign ctl_div1 = '{advance: adv, valid: vld_s2};

	lufx_div #(.NB(NB1), .DB(MW), .QB(RW), .PW(P1W)) u_ratio_div (
		.clk(clk),
		.arst_n(arst_n),
		.in_ctl(ctl_div1),
		.dividend({ndiv_s2, {F{1'b0}}}),
		.divisor(dmag_s2),
		.in_payload({tail_s2, smag_s2, sneg_s2, rneg_s2, special_s2, clip_s2}),
		.out_valid(vld_d1),
		.quotient(q1),
		.out_payload(pay_d1)
	);

	assign {tail_d1, smag_d1, sneg_d1, rneg_d1, special_d1, clip_d1} = pay_d1;

	// ratio select and clip
	logic          over_r;
	logic          vld_s3;
	logic [RW-1:0] rmag_s3;
	logic          sat_s3;
	logic          rneg_s3;
	logic [TW-1:0] tail_s3;
	logic [MW-1:0] smag_s3;
	logic          sneg_s3;

	assign over_r = clip_d1 || (q1 > LIM_Q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (adv) begin
			vld_s3 <= vld_d1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rmag_s3 <= special_d1 ? ONE_Q : (over_r ? LIM_Q : q1);
			sat_s3 <= !special_d1 && over_r;
			rneg_s3 <= !special_d1 && rneg_d1;
			tail_s3 <= tail_d1;
			smag_s3 <= smag_d1;
			sneg_s3 <= sneg_d1;
		end
	end

	// r squared
	pipe_ctl_t      ctl_sq;
	logic           vld_m1;
	logic [2*RW-1:0] sq_prod;
	logic [P2W-1:0] pay_m1;
	logic [P3W-1:0] rest_m1;
	logic [RW-1:0]  rmag_m1;

	assign ctl_sq = '{advance: adv, valid: vld_s3};

	lufx_mul #(.AW(RW), .BW(RW), .PW(P2W)) u_square_mul (
		.clk(clk),
		.arst_n(arst_n),
		.in_ctl(ctl_sq),
		.a(rmag_s3),
		.b(rmag_s3),
		.in_payload({tail_s3, smag_s3, sneg_s3, rneg_s3, sat_s3, rmag_s3}),
		.out_valid(vld_m1),
		.product(sq_prod),
		.out_payload(pay_m1)
	);

	assign {rest_m1, rmag_m1} = pay_m1;

	// limiter denominator r*r + 1
	logic           vld_s4;
	logic [DB2-1:0] dvs2_s4;
	logic [RW-1:0]  rmag_s4;
	logic [P3W-1:0] rest_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (adv) begin
			vld_s4 <= vld_m1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dvs2_s4 <= DB2'(sq_prod >> F) + DB2'(ONE_Q);
			rmag_s4 <= rmag_m1;
			rest_s4 <= rest_m1;
		end
	end

	// limiter divider, phi never exceeds one
	pipe_ctl_t      ctl_div2;
	logic           vld_d2;
	logic [QB2-1:0] pmag;
	logic [P3W-1:0] pay_d2;
	logic [TW-1:0]  tail_d2;
	logic [MW-1:0]  smag_d2;
	logic           sneg_d2;
	logic           rneg_d2;
	logic           sat_d2;

	assign ctl_div2 = '{advance: adv, valid: vld_s4};

	lufx_div #(.NB(NB2), .DB(DB2), .QB(QB2), .PW(P3W)) u_limiter_div (
		.clk(clk),
		.arst_n(arst_n),
		.in_ctl(ctl_div2),
		.dividend({rmag_s4, {(F + 1){1'b0}}}),
		.divisor(dvs2_s4),
		.in_payload(rest_s4),
		.out_valid(vld_d2),
		.quotient(pmag),
		.out_payload(pay_d2)
	);

	assign {tail_d2, smag_d2, sneg_d2, rneg_d2, sat_d2} = pay_d2;

	// correction phi * spread
	pipe_ctl_t         ctl_corr;
	logic              vld_m2;
	logic [QB2+MW-1:0] corr_prod;
	logic [P4W-1:0]    pay_m2;
	logic [V-1:0]      center_m2;
	logic [V-1:0]      speed_m2;
	logic [V-2:0]      dtdx_m2;
	logic              higher_m2;
	logic              cneg_m2;
	logic              sat_m2;
	logic [V-1:0]      corr;

	assign ctl_corr = '{advance: adv, valid: vld_d2};

	lufx_mul #(.AW(QB2), .BW(MW), .PW(P4W)) u_corr_mul (
		.clk(clk),
		.arst_n(arst_n),
		.in_ctl(ctl_corr),
		.a(pmag),
		.b(smag_d2),
		.in_payload({tail_d2, rneg_d2 ^ sneg_d2, sat_d2}),
		.out_valid(vld_m2),
		.product(corr_prod),
		.out_payload(pay_m2)
	);

	assign {center_m2, speed_m2, dtdx_m2, higher_m2, cneg_m2, sat_m2} = pay_m2;
	assign corr = corr_prod[F+V+1:F+2];

	// inner value, then its magnitude and sign
	logic          vld_s5;
	logic [IW-1:0] inner_s5;
	logic [V-1:0]  speed_s5;
	logic [V-2:0]  dtdx_s5;
	logic          higher_s5;
	logic          sat_s5;
	logic          vld_s6;
	logic [V:0]    imag_s6;
	logic          ineg_s6;
	logic [V-1:0]  speed_s6;
	logic [V-2:0]  dtdx_s6;
	logic          higher_s6;
	logic          sat_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else if (adv) begin
			vld_s5 <= vld_m2;
			vld_s6 <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			inner_s5 <= cneg_m2 ?
				{{2{center_m2[V-1]}}, center_m2} - {2'b00, corr} :
				{{2{center_m2[V-1]}}, center_m2} + {2'b00, corr};
			speed_s5 <= speed_m2;
			dtdx_s5 <= dtdx_m2;
			higher_s5 <= higher_m2;
			sat_s5 <= sat_m2;
			imag_s6 <= inner_s5[IW-1] ? (V+1)'(~inner_s5 + 1'b1) : inner_s5[V:0];
			ineg_s6 <= inner_s5[IW-1];
			speed_s6 <= speed_s5;
			dtdx_s6 <= dtdx_s5;
			higher_s6 <= higher_s5;
			sat_s6 <= sat_s5;
		end
	end

	// |inner| * speed
	pipe_ctl_t      ctl_spd;
	logic           vld_m3;
	logic [2*V:0]   spd_prod;
	logic [P5W-1:0] pay_m3;
	logic [V-2:0]   dtdx_m3;
	logic [2:0]     flags_m3;

	assign ctl_spd = '{advance: adv, valid: vld_s6};

	lufx_mul #(.AW(V + 1), .BW(V), .PW(P5W)) u_speed_mul (
		.clk(clk),
		.arst_n(arst_n),
		.in_ctl(ctl_spd),
		.a(imag_s6),
		.b(speed_s6),
		.in_payload({dtdx_s6, higher_s6, sat_s6, ineg_s6}),
		.out_valid(vld_m3),
		.product(spd_prod),
		.out_payload(pay_m3)
	);

	assign {dtdx_m3, flags_m3} = pay_m3;

	// times dt/dx
	pipe_ctl_t       ctl_dt;
	logic            vld_m4;
	logic [XW+V-2:0] dt_prod;
	logic            higher_m4;
	logic            sat_m4;
	logic            ineg_m4;

	assign ctl_dt = '{advance: adv, valid: vld_m3};

	lufx_mul #(.AW(XW), .BW(V - 1), .PW(3)) u_step_mul (
		.clk(clk),
		.arst_n(arst_n),
		.in_ctl(ctl_dt),
		.a(spd_prod[2*V:F]),
		.b(dtdx_m3),
		.in_payload(flags_m3),
		.out_valid(vld_m4),
		.product(dt_prod),
		.out_payload({higher_m4, sat_m4, ineg_m4})
	);

	// flux clip and sign
	logic [MFW-1:0] fmag;
	logic [MFW-1:0] flim;
	logic           fover;
	logic [V-1:0]   fclip;
	logic [V-1:0]   flux_q;
	logic           higher_q;
	logic           sat_q;

	assign fmag = dt_prod[XW+V-2:F];
	assign flim = ineg_m4 ? HALF_M : HALF_M - 1'b1;
	assign fover = fmag > flim;
	assign fclip = V'(fover ? flim : fmag);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (adv) begin
			m_valid_q <= vld_m4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			flux_q <= ineg_m4 ? V'(~fclip + 1'b1) : fclip;
			higher_q <= higher_m4;
			sat_q <= sat_m4 || fover;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata = OUT_DW'(flux_q);
	assign m_axis_tuser = {sat_q, higher_q};

endmodule

@@ rtl/lufx_checker.sv @@
module lufx_checker #(
	parameter int VALUE_BITS = 32
) (
	input logic clk,
	input logic arst_n,
	input logic s_axis_tvalid,
	input logic s_axis_tready,
	input logic m_axis_tvalid,
	input logic m_axis_tready,
	input logic [((VALUE_BITS+7)/8)*8-1:0] m_axis_tdata,
	input logic [1:0] m_axis_tuser
);
	import lufx_pkg::*;

	// a held result word keeps its value
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
		m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("result word changed while stalled");

	// an empty output stage never blocks the input
	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input stalled with empty output");

	// a word taken at the output frees the input in the same cycle
	a_take_ready: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tready |-> s_axis_tready)
		else $error("input stalled while output drains");

	// a held result word freezes the pipeline and blocks the input
	a_stall_ready: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
		else $error("input accepted while output stalled");

	// reset clears the output valid
	a_reset: assert property (@(posedge clk)
		!arst_n |=> !m_axis_tvalid)
		else $error("output valid during reset");

endmodule

bind limited_upwind_advection_flux lufx_checker #(.VALUE_BITS(VALUE_BITS)) u_checker (.*);

@@ tb/sv/tb_limited_upwind_advection_flux.sv @@
`timescale 1ns / 1ps

module tb_limited_upwind_advection_flux;

	localparam int VB = 32;
	localparam int FB = 24;
	localparam longint unsigned ONE_Q = 64'd1 << FB;
	localparam longint unsigned FRAC_MASK = ONE_Q - 64'd1;

	typedef struct {
		logic signed [31:0] left_value;
		logic signed [31:0] center_value;
		logic signed [31:0] right_value;
		logic signed [31:0] velocity;
		logic [30:0] step_over_width;
	} cell_t;

	typedef struct {
		logic [31:0] flux;
		logic toward_higher;
		logic saturated;
	} flux_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	// left_value, center_value, right_value, velocity, step_over_width
	logic [159:0] s_axis_tdata = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	// flux
	logic [31:0] m_axis_tdata;
	// toward_higher, saturated
	logic [1:0] m_axis_tuser;

	cell_t cells_pending[$];
	flux_t flux_expected[$];
	int errors = 0;
	int words_in = 0;
	int words_out = 0;
	int sat_seen = 0;
	int neg_vel_seen = 0;
	logic s_fire = 1'b0;
	bit stim_done = 1'b0;

	limited_upwind_advection_flux #(.VALUE_BITS(VB), .FRACTION_BITS(FB)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser)
	);

	always #1 clk = ~clk;

	// floor(a*b / 2^F) on magnitudes
	function automatic longint unsigned q_mul(longint unsigned a, longint unsigned b);
		return (a >> FB) * b + (((a & FRAC_MASK) * b) >> FB);
	endfunction

	function automatic longint unsigned mag64(longint x);
		return x < 0 ? 64'd0 - longint'(x) : x;
	endfunction

	// limited upwind flux of one cell
	function automatic flux_t limited_flux(cell_t c);
		flux_t f;
		longint lv, cv, rv, vv, up, down, num, den, spread, inner;
		longint unsigned speed, rmag, q, sq, pmag, corr, m, lim, half;
		bit higher, sat, rneg, cneg, fneg;
		lv = c.left_value;
		cv = c.center_value;
		rv = c.right_value;
		vv = c.velocity;
		higher = vv > 0;
		up = higher ? lv : rv;
		down = higher ? rv : lv;
		speed = mag64(vv);
		sat = 1'b0;
		rmag = ONE_Q;
		rneg = 1'b0;
		if (speed != 0 && cv != up) begin
			num = down - cv;
			den = cv - up;
			q = (mag64(num) << FB) / mag64(den);
			lim = 64'd32767 << FB;
			if (q > lim) begin
				q = lim;
				sat = 1'b1;
			end
			rmag = q;
			rneg = (num < 0) != (den < 0);
		end
		sq = q_mul(rmag, rmag);
		pmag = ((64'd2 * rmag) << FB) / (sq + ONE_Q);
		spread = down - up;
		corr = (pmag * mag64(spread)) >> (FB + 2);
		cneg = rneg != (spread < 0);
		inner = cneg ? cv - longint'(corr) : cv + longint'(corr);
		m = q_mul(q_mul(mag64(inner), speed), 64'(c.step_over_width));
		fneg = inner < 0;
		half = 64'd1 << (VB - 1);
		lim = fneg ? half : half - 64'd1;
		if (m > lim) begin
			m = lim;
			sat = 1'b1;
		end
		f.flux = fneg ? 32'(64'd0 - m) : 32'(m);
		f.toward_higher = higher;
		f.saturated = sat;
		return f;
	endfunction

	function automatic cell_t mk(int unsigned l, int unsigned c, int unsigned r,
			int unsigned v, int unsigned d);
		cell_t x;
		x.left_value = l;
		x.center_value = c;
		x.right_value = r;
		x.velocity = v;
		x.step_over_width = d[30:0];
		return x;
	endfunction

	// moderate Q8.24 value around +-4
	function automatic int unsigned mild();
		return $urandom_range(0, 32'h0800_0000) - 32'h0400_0000;
	endfunction

	// stimulus: directed corners, then random cells
	initial begin
		int unsigned c, mode;
		cell_t x;
		cells_pending.push_back(mk(32'h0100_0000, 32'h0200_0000, 32'h0300_0000, 0, 32'h0100_0000));
		cells_pending.push_back(mk(32'h0100_0000, 32'h0100_0000, 32'h0500_0000,
			32'h0100_0000, 32'h0080_0000));
		cells_pending.push_back(mk(32'h0500_0000, 32'h0100_0000, 32'h0100_0000,
			32'hff00_0000, 32'h0080_0000));
		cells_pending.push_back(mk(0, 1, 32'h7fff_ffff, 32'h0100_0000, 32'h0100_0000));
		cells_pending.push_back(mk(32'h8000_0000, 32'h8000_0001, 32'h7fff_ffff,
			32'h0100_0000, 32'h0100_0000));
		cells_pending.push_back(mk(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
			32'h7fff_ffff, 32'h7fff_ffff));
		cells_pending.push_back(mk(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			32'h8000_0000, 32'h7fff_ffff));
		cells_pending.push_back(mk(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
			32'h8000_0000, 32'h7fff_ffff));
		cells_pending.push_back(mk(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
			32'h7fff_ffff, 32'h7fff_ffff));
		cells_pending.push_back(mk(32'h0100_0000, 32'h0200_0000, 32'h0300_0000,
			32'h0100_0000, 0));
		cells_pending.push_back(mk(32'h0100_0000, 32'h0200_0000, 32'h0300_0000,
			32'hffff_ffff, 32'h7fff_ffff));
		cells_pending.push_back(mk(32'h0100_0000, 32'h0200_0000, 32'h0100_0000,
			32'h0000_0001, 32'h0100_0000));
		cells_pending.push_back(mk(32'h0300_0000, 32'h0200_0000, 32'h0100_0000,
			32'h0100_0000, 32'h0100_0000));
		cells_pending.push_back(mk(32'hfd00_0000, 32'hfe00_0000, 32'hff00_0000,
			32'hfe00_0000, 32'h0040_0000));
		cells_pending.push_back(mk(0, 0, 0, 32'h0100_0000, 32'h0100_0000));
		cells_pending.push_back(mk(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
			32'h0000_0001, 32'h7fff_ffff));
		for (int i = 0; i < 400; i++) begin
			mode = $urandom_range(0, 9);
			if (mode < 5) begin
				x = mk(mild(), mild(), mild(), mild(), $urandom_range(0, 32'h0200_0000));
			end else if (mode == 5) begin
				// centre equal to the left or the right neighbour
				c = mild();
				x = mk(c, c, c + ($urandom_range(0, 1) ? $urandom() : mild()), mild(),
					$urandom());
				if ($urandom_range(0, 1)) begin
					x.right_value = c;
					x.left_value = c + mild();
				end
			end else if (mode == 6) begin
				// tiny step to the left neighbour, huge ratio when that side is upwind
				c = mild();
				x = mk(c - $urandom_range(1, 3), c, c + $urandom(), mild(), $urandom());
				if ($urandom_range(0, 1)) x.velocity = -x.velocity;
			end else if (mode == 7) begin
				x = mk(mild(), mild(), mild(), 0, $urandom());
			end else begin
				x = mk($urandom(), $urandom(), $urandom(), $urandom(), $urandom());
			end
			cells_pending.push_back(x);
		end
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	// handshake seen at the edge, consumed at the next falling edge
	always @(posedge clk) begin
		s_fire <= s_axis_tvalid && s_axis_tready;
	end

	// driver: bursts with random gaps, holds the word until taken
	int burst_left = 4;
	int gap_left = 0;
	always @(negedge clk) begin
		if (arst_n) begin
			if (s_fire) begin
				flux_expected.push_back(limited_flux(cells_pending.pop_front()));
				words_in++;
			end
			if (!(s_axis_tvalid && !s_fire)) begin
				if (gap_left > 0 || cells_pending.size() == 0) begin
					s_axis_tvalid <= 1'b0;
					if (gap_left > 0) gap_left--;
					if (cells_pending.size() == 0) stim_done = 1'b1;
				end else begin
					s_axis_tvalid <= 1'b1;
					s_axis_tdata <= {1'b0, cells_pending[0].step_over_width,
						cells_pending[0].velocity, cells_pending[0].right_value,
						cells_pending[0].center_value, cells_pending[0].left_value};
					burst_left--;
					if (burst_left <= 0) begin
						burst_left = $urandom_range(1, 40);
						gap_left = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6);
					end
				end
			end
		end
	end

	// receiver stall pattern, with one long hold-off to fill the pipeline
	int rx_cycle = 0;
	int hold_left = 0;
	bit hold_done = 1'b0;
	always @(negedge clk) begin
		if (arst_n) begin
			rx_cycle++;
			if (!hold_done && words_in >= 60) begin
				hold_done = 1'b1;
				hold_left = 300;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else if ((rx_cycle / 256) % 2 == 0) begin
				m_axis_tready <= 1'b1;
			end else begin
				m_axis_tready <= ($urandom_range(0, 2) != 0) && (rx_cycle % 7 != 3);
			end
		end
	end

	// monitor: compare each output word with the oldest prediction
	always @(posedge clk) begin
		flux_t e;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (flux_expected.size() == 0) begin
				$error("output word with no prediction: flux=%h", m_axis_tdata);
				errors++;
			end else begin
				e = flux_expected.pop_front();
				words_out++;
				if (e.saturated) sat_seen++;
				if (!e.toward_higher) neg_vel_seen++;
				if (m_axis_tdata !== e.flux) begin
					$error("flux expected %h actual %h", e.flux, m_axis_tdata);
					errors++;
				end
				if (m_axis_tuser[0] !== e.toward_higher) begin
					$error("toward_higher expected %b actual %b", e.toward_higher,
						m_axis_tuser[0]);
					errors++;
				end
				if (m_axis_tuser[1] !== e.saturated) begin
					$error("saturated expected %b actual %b", e.saturated, m_axis_tuser[1]);
					errors++;
				end
			end
		end
	end

	// end of run
	initial begin
		wait (arst_n);
		wait (stim_done && flux_expected.size() == 0 && !s_fire);
		repeat (200) @(posedge clk);
		if (flux_expected.size() != 0) errors++;
		$display("cells sent %0d, flux words checked %0d (%0d clipped, %0d not toward higher)",
			words_in, words_out, sat_seen, neg_vel_seen);
		if (errors == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

	// watchdog
	initial begin
		#2000000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
